>>> hw/rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 edge-aware box blur.
`default_nettype none
package bb3_pkg;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic        CFG_FRAME_WIDTH  = 1'b0;
  localparam logic        CFG_FRAME_HEIGHT = 1'b1;
  localparam int          DIV_STEPS        = 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_OUTPUT = 4'b1000
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/bb3_ctrl.sv
// Controller state machine for the box blur.
`default_nettype none
module bb3_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  input  wire bb3_pkg::sts_t sts_i,
  output bb3_pkg::cmd_t cmd_o
);

  bb3_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bb3_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bb3_pkg::S_UPDATE;
      end
      bb3_pkg::S_UPDATE: begin
        state_d = sts_i.emit ? bb3_pkg::S_DIVIDE : bb3_pkg::S_IDLE;
      end
      bb3_pkg::S_DIVIDE: begin
        if (sts_i.div_last) state_d = bb3_pkg::S_OUTPUT;
      end
      bb3_pkg::S_OUTPUT: begin
        if (!out_stall_i) state_d = bb3_pkg::S_IDLE;
      end
      default: state_d = bb3_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bb3_pkg::S_IDLE;
    else state_q <= state_d;
  end

  assign in_stall_o       = (state_q != bb3_pkg::S_IDLE);
  assign out_valid_o      = (state_q == bb3_pkg::S_OUTPUT);
  assign cmd_o.capture    = (state_q == bb3_pkg::S_IDLE) && in_valid_i;
  assign cmd_o.update     = (state_q == bb3_pkg::S_UPDATE);
  assign cmd_o.div_step   = (state_q == bb3_pkg::S_DIVIDE);

endmodule
`default_nettype wire

>>> hw/rtl/bb3_datapath.sv
// Datapath: line stores, window, position counters, sums and serial divider.
`default_nettype none
module bb3_datapath #(
  parameter int MAX_LINE = 1024
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           cfg_we_i,
  input  wire           cfg_index_i,
  input  wire  [11:0]   cfg_data_i,
  input  wire           kind_i,
  input  wire  [7:0]    in_red_i,
  input  wire  [7:0]    in_green_i,
  input  wire  [7:0]    in_blue_i,
  input  wire bb3_pkg::cmd_t cmd_i,
  output bb3_pkg::sts_t sts_o,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic          frame_end_o
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int WW = $clog2(MAX_LINE + 1);
  localparam int EW = (WW > 11) ? WW : 11;

  logic [23:0] upper_mem [MAX_LINE];
  logic [23:0] middle_mem [MAX_LINE];

  logic [10:0] fw_q;
  logic [11:0] fh_q;
  logic [AW-1:0] in_col_q, out_col_q, ic_q;
  logic [12:0] in_row_q;
  logic [11:0] out_row_q;
  logic [23:0] win_q [9];
  logic [23:0] above2_q, above1_q, data_q;

  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [EW-1:0] fw_ext;
  logic [AW-1:0] ic_cur;

  assign fw_ext = EW'(fw_q);
  always_comb begin
    if (fw_q == 11'd0) w_eff = WW'(1);
    else if (fw_ext > EW'(MAX_LINE)) w_eff = WW'(MAX_LINE);
    else w_eff = WW'(fw_q);
  end
  assign h_eff  = (fh_q == 12'd0) ? 12'd1 : fh_q;
  assign ic_cur = (WW'(in_col_q) >= w_eff) ? '0 : in_col_q;

  // capture request, read line stores and write them back on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      above2_q <= upper_mem[ic_cur];
      above1_q <= middle_mem[ic_cur];
      ic_q     <= ic_cur;
      data_q   <= kind_i ? 24'd0 : {in_red_i, in_green_i, in_blue_i};
    end
    if (cmd_i.update) begin
      upper_mem[ic_q]  <= above1_q;
      middle_mem[ic_q] <= data_q;
    end
  end

  // window update
  logic [23:0] emit_win [9];
  logic [23:0] fin_win [9];
  logic        ready, col0;
  assign col0  = (ic_q == '0);
  assign ready = (in_row_q > 13'd1) || ((in_row_q == 13'd1) && !col0);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (col0) begin
        emit_win[r*3+0] = win_q[r*3+1];
        emit_win[r*3+1] = win_q[r*3+2];
        emit_win[r*3+2] = 24'd0;
        fin_win[r*3+0]  = win_q[r*3+2];
        fin_win[r*3+1]  = 24'd0;
      end else begin
        emit_win[r*3+0] = win_q[r*3+1];
        emit_win[r*3+1] = win_q[r*3+2];
        fin_win[r*3+0]  = win_q[r*3+1];
        fin_win[r*3+1]  = win_q[r*3+2];
        emit_win[r*3+2] = (r == 0) ? above2_q : ((r == 1) ? above1_q : data_q);
      end
      fin_win[r*3+2] = (r == 0) ? above2_q : ((r == 1) ? above1_q : data_q);
    end
  end

  // neighbourhood sums, divisor and last-pixel flag
  logic [2:0]  row_ok, col_ok;
  logic [3:0]  count, cnt_eff;
  logic [11:0] sum [3];
  logic [12:0] numer [3];
  logic [4:0]  denom;
  logic        last;

  always_comb begin
    row_ok[0] = (out_row_q != 12'd0);
    row_ok[1] = (out_row_q < h_eff);
    row_ok[2] = ({1'b0, out_row_q} + 13'd1) < {1'b0, h_eff};
    col_ok[0] = (out_col_q != '0);
    col_ok[1] = (WW'(out_col_q) < w_eff);
    col_ok[2] = ((WW'(out_col_q) + WW'(1)) < w_eff);
    count = 4'd0;
    for (int ch = 0; ch < 3; ch++) sum[ch] = 12'd0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          count = count + 4'd1;
          sum[0] = sum[0] + 12'(emit_win[r*3+c][23:16]);
          sum[1] = sum[1] + 12'(emit_win[r*3+c][15:8]);
          sum[2] = sum[2] + 12'(emit_win[r*3+c][7:0]);
        end
      end
    end
    cnt_eff = (count == 4'd0) ? 4'd1 : count;
    denom   = {cnt_eff, 1'b0};
    for (int ch = 0; ch < 3; ch++) numer[ch] = {sum[ch], 1'b0} + 13'(cnt_eff);
    last = (out_row_q == h_eff - 12'd1) && (WW'(out_col_q) == w_eff - WW'(1));
  end

  // frame size registers, position counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= bb3_pkg::FRAME_WIDTH_RST;
      fh_q      <= bb3_pkg::FRAME_HEIGHT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= 24'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bb3_pkg::CFG_FRAME_WIDTH) fw_q <= cfg_data_i[10:0];
      else fh_q <= cfg_data_i;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cmd_i.update) begin
      for (int i = 0; i < 9; i++) win_q[i] <= fin_win[i];
      if (ready && last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if ((WW'(ic_q) + WW'(1)) >= w_eff) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 13'd1;
        end else begin
          in_col_q <= ic_q + AW'(1);
        end
        if (ready) begin
          if ((WW'(out_col_q) + WW'(1)) >= w_eff) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 12'd1;
          end else begin
            out_col_q <= out_col_q + AW'(1);
          end
        end
      end
    end
  end

  // serial divider, one quotient bit per channel per cycle
  logic [4:0] rem_q [3];
  logic [7:0] low_q [3];
  logic [7:0] quo_q [3];
  logic [4:0] den_q;
  logic [2:0] step_q;
  logic       fend_q;
  logic [5:0] trial [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) trial[ch] = {rem_q[ch], low_q[ch][7]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      den_q  <= denom;
      fend_q <= last;
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= numer[ch][12:8];
        low_q[ch] <= numer[ch][7:0];
      end
    end else if (cmd_i.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (trial[ch] >= {1'b0, den_q}) begin
          rem_q[ch] <= 5'(trial[ch] - {1'b0, den_q});
          quo_q[ch] <= {quo_q[ch][6:0], 1'b1};
        end else begin
          rem_q[ch] <= trial[ch][4:0];
          quo_q[ch] <= {quo_q[ch][6:0], 1'b0};
        end
        low_q[ch] <= {low_q[ch][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= '0;
    else if (cmd_i.update) step_q <= '0;
    else if (cmd_i.div_step) step_q <= step_q + 3'd1;
  end

  assign sts_o.emit     = ready;
  assign sts_o.div_last = (step_q == 3'(bb3_pkg::DIV_STEPS - 1));
  assign out_red_o      = quo_q[0];
  assign out_green_o    = quo_q[1];
  assign out_blue_o     = quo_q[2];
  assign frame_end_o    = fend_q;

endmodule
`default_nettype wire

>>> hw/rtl/box_blur_3x3_edge_aware.sv
// Top level of the streaming 3x3 edge-aware box blur.
// Input channel: in_valid_i / in_stall_o, one pixel (kind_i = 0) or drain
// item (kind_i = 1) per request, raster order. Output channel: out_valid_o /
// out_stall_i with the blurred RGB pixel and frame_end_o on the last one.
// Output lags input by one row plus one pixel; after the frame, width+1
// drain requests flush the remaining outputs.
// Per request: state S_IDLE accepts it and reads the line stores, S_UPDATE
// shifts the window and sums the neighbourhood. A request with no output is
// then done. One with an output goes on through the bit-serial divider
// (S_DIVIDE) and then S_OUTPUT.
// The output pixel is held until the receiver drops out_stall_i; no new
// request is taken meanwhile.
// Reset: frame_width = 640, frame_height = 480, counters and window zero.
// A configuration write restarts the frame; write only while idle (the user is bound, the block does not enforce it).
`default_nettype none
module box_blur_3x3_edge_aware #(
  parameter int MAX_LINE = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [11:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         kind_i,
  input  wire  [7:0]  in_red_i,
  input  wire  [7:0]  in_green_i,
  input  wire  [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_end_o
);

  bb3_pkg::cmd_t cmd;
  bb3_pkg::sts_t sts;

  bb3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bb3_datapath #(.MAX_LINE(MAX_LINE)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .kind_i     (kind_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .frame_end_o(frame_end_o)
  );

endmodule
`default_nettype wire
